/* rtl/otpr_pkg.sv */
package otpr_pkg;

    localparam int LINE_COUNT_DEF     = 8;
    localparam int SCREEN_WIDTH_DEF   = 128;
    localparam int GLYPH_WIDTH_DEF    = 5;
    localparam int CHARS_PER_LINE_DEF = 21;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CHAR   = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_FONT   = 3'd4;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAULT   = 2'd1;
    localparam logic [1:0] ST_BADLINE = 2'd2;

    localparam logic [1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
    localparam logic [1:0] ALIGN_CENTER = 2'd2;

    localparam logic [3:0] PH_ADDR1 = 4'd0;
    localparam logic [3:0] PH_CMD0  = 4'd1;
    localparam logic [3:0] PH_PAGE  = 4'd2;
    localparam logic [3:0] PH_COLLO = 4'd3;
    localparam logic [3:0] PH_COLHI = 4'd4;
    localparam logic [3:0] PH_STOP1 = 4'd5;
    localparam logic [3:0] PH_ADDR2 = 4'd6;
    localparam logic [3:0] PH_DATA1 = 4'd7;
    localparam logic [3:0] PH_DATAN = 4'd8;
    localparam logic [3:0] PH_STOP2 = 4'd9;
    localparam logic [3:0] PH_END   = 4'd10;

    localparam logic [7:0] CMD_ZERO  = 8'h00;
    localparam logic [7:0] CMD_PAGE  = 8'hB0;
    localparam logic [7:0] CMD_COLHI = 8'h10;
    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [6:0] ADDR_RESET = 7'h3c;
    localparam logic [4:0] CURSOR_MAX = 5'd31;

    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_ADDRESS = 1'b1;

    typedef struct packed {
        logic [2:0] opcode;
        logic       bus_ok;
        logic       bus_fault;
        logic       line_bad;
        logic [2:0] line;
        logic [4:0] slot;
        logic       slot_ok;
        logic [7:0] value;
        logic [7:0] glyph;
        logic [2:0] gcol;
        logic       gcol_ok;
        logic       align_set;
        logic [7:0] start;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic       write;
        logic       index;
        logic [6:0] data;
    } cfg_t;

endpackage

/* rtl/otpr_queue.sv */
module otpr_queue import otpr_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/otpr_front.sv */
module otpr_front import otpr_pkg::*; #(
    parameter int LINE_COUNT     = LINE_COUNT_DEF,
    parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
    parameter int GLYPH_WIDTH    = GLYPH_WIDTH_DEF,
    parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] opcode,
    input  logic       bus_done,
    input  logic       bus_nack,
    input  logic       bus_fault,
    input  logic [2:0] line_index,
    input  logic [4:0] char_position,
    input  logic [7:0] byte_value,
    input  logic [7:0] glyph_index,
    input  logic [2:0] glyph_column,
    input  logic [1:0] alignment,
    input  logic [4:0] text_length,
    input  logic       item_pop,
    output logic       item_valid,
    output item_t      item
);

    localparam int SLOTS = CHARS_PER_LINE + 1;
    localparam int CELL  = GLYPH_WIDTH + 1;
    localparam int WIDTH_ITEM = $bits(item_t);

    item_t       dec;
    logic [4:0]  len;
    logic [9:0]  w;
    logic [9:0]  room;
    logic [WIDTH_ITEM-1:0] q_rdata;

    always_comb
    begin
        len  = (text_length > 5'(CHARS_PER_LINE)) ? 5'(CHARS_PER_LINE) : text_length;
        w    = 10'(len) * 10'(CELL);
        room = (w < 10'(SCREEN_WIDTH)) ? 10'(SCREEN_WIDTH) - w : '0;
        dec           = '0;
        dec.opcode    = opcode;
        dec.bus_ok    = bus_done && !bus_nack;
        dec.bus_fault = bus_fault;
        dec.line_bad  = ({1'b0, line_index} >= 4'(LINE_COUNT));
        dec.line      = line_index;
        dec.value     = byte_value;
        dec.glyph     = glyph_index;
        dec.gcol      = glyph_column;
        dec.gcol_ok   = ({1'b0, glyph_column} < 4'(GLYPH_WIDTH));
        if (opcode == OP_COMMIT)
        begin
            dec.slot    = len;
            dec.slot_ok = 1'b1;
        end
        else
        begin
            dec.slot    = char_position;
            dec.slot_ok = ({1'b0, char_position} < 6'(SLOTS));
        end
        dec.align_set = 1'b1;
        case (alignment)
            ALIGN_LEFT:   dec.start = '0;
            ALIGN_RIGHT:  dec.start = room[7:0];
            ALIGN_CENTER: dec.start = room[8:1];
            default:      dec.align_set = 1'b0;
        endcase
    end

    otpr_queue #(
        .WIDTH(WIDTH_ITEM),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(dec),
        .full (full),
        .pop  (item_pop),
        .rdata(q_rdata),
        .valid(item_valid)
    );

    assign item = q_rdata;

endmodule

/* rtl/otpr_back.sv */
module otpr_back import otpr_pkg::*; #(
    parameter int LINE_COUNT     = LINE_COUNT_DEF,
    parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
    parameter int GLYPH_WIDTH    = GLYPH_WIDTH_DEF,
    parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_pop,
    input  logic    out_full,
    output logic    res_push,
    output result_t res
);

    localparam int SLOTS = CHARS_PER_LINE + 1;
    localparam int CELL  = GLYPH_WIDTH + 1;
    localparam int RECIP = 65536 / CELL + 1;
    localparam int LW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int TAW   = $clog2(LINE_COUNT * SLOTS);
    localparam int FAW   = $clog2(256 * GLYPH_WIDTH);

    localparam logic [1:0] S_EXEC = 2'd0;
    localparam logic [1:0] S_TXT  = 2'd1;
    localparam logic [1:0] S_FNT  = 2'd2;

    logic [7:0] text_mem [LINE_COUNT * SLOTS];
    logic [7:0] font_mem [256 * GLYPH_WIDTH];

    logic [1:0] state_reg, state_next;
    logic       enabled_reg, enabled_next;
    logic [6:0] addr_reg, addr_next;
    logic [3:0] phase_reg, phase_next;
    logic       awaiting_reg, awaiting_next;
    logic       stop_reg, stop_next;
    logic [2:0] page_reg, page_next;
    logic [7:0] pixel_reg, pixel_next;
    logic [4:0] cursor_reg, cursor_next;
    logic [7:0] cidx_reg, cidx_next;
    logic [7:0] start_reg [LINE_COUNT];
    logic [7:0] start_next [LINE_COUNT];
    logic [LINE_COUNT-1:0] ended_reg, ended_next;
    logic [LINE_COUNT-1:0] rendered_reg, rendered_next;

    logic           text_we, text_re, font_we, font_re;
    logic [TAW-1:0] text_waddr, text_raddr;
    logic [7:0]     text_wdata, text_rdata;
    logic [FAW-1:0] font_waddr, font_raddr;
    logic [7:0]     font_rdata;

    logic [LW-1:0] pg, ln;
    logic [7:0]    start_cur;
    logic [7:0]    pix_inc;
    logic [7:0]    cell_pos;
    logic [2:0]    page_inc;
    logic          advance;

    // remainder by the cell width through a reciprocal multiply
    function automatic logic [7:0] mod_cell(input logic [7:0] v);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [11:0] qc;
        prod = 25'(v) * 25'(RECIP);
        q    = prod[23:16];
        qc   = 12'(q) * 12'(CELL);
        return v - qc[7:0];
    endfunction

    always_comb
    begin
        pg        = page_reg[LW-1:0];
        ln        = item.line[LW-1:0];
        start_cur = start_reg[pg];
        pix_inc   = pixel_reg + 8'd1;
        cell_pos  = mod_cell(pixel_reg - start_cur);
        page_inc  = ({1'b0, page_reg} + 4'd1 >= 4'(LINE_COUNT)) ? 3'd0 : page_reg + 3'd1;

        state_next    = state_reg;
        enabled_next  = enabled_reg;
        addr_next     = addr_reg;
        phase_next    = phase_reg;
        awaiting_next = awaiting_reg;
        stop_next     = stop_reg;
        page_next     = page_reg;
        pixel_next    = pixel_reg;
        cursor_next   = cursor_reg;
        cidx_next     = cidx_reg;
        start_next    = start_reg;
        ended_next    = ended_reg;
        rendered_next = rendered_reg;
        advance       = 1'b0;

        text_we    = 1'b0;
        text_waddr = TAW'(11'(item.line) * 11'(SLOTS) + 11'(item.slot));
        text_wdata = '0;
        text_re    = 1'b0;
        text_raddr = TAW'(11'(page_reg) * 11'(SLOTS) + 11'(cursor_reg));
        font_we    = 1'b0;
        font_waddr = FAW'(16'(item.glyph) * 16'(GLYPH_WIDTH) + 16'(item.gcol));
        font_re    = 1'b0;
        font_raddr = FAW'(16'(text_rdata) * 16'(GLYPH_WIDTH) + 16'(cidx_reg));

        item_pop = 1'b0;
        res_push = 1'b0;
        res      = '0;

        if (cfg.write)
        begin
            case (cfg.index)
                CFG_ENABLED: enabled_next = cfg.data[0];
                default:     addr_next    = cfg.data;
            endcase
        end

        case (state_reg)
            S_EXEC:
            begin
                if (item_valid && !out_full)
                begin
                    item_pop = 1'b1;
                    res_push = 1'b1;
                    case (item.opcode)
                        OP_TICK:
                        begin
                            if (enabled_reg && awaiting_reg)
                            begin
                                if (stop_reg || item.bus_ok)
                                begin
                                    stop_next     = 1'b0;
                                    awaiting_next = 1'b0;
                                    advance       = 1'b1;
                                    if (phase_reg == PH_DATAN)
                                    begin
                                        pixel_next = pix_inc;
                                        if (pixel_reg >= start_cur &&
                                            cell_pos == 8'(CELL - 1) &&
                                            cursor_reg != CURSOR_MAX)
                                        begin
                                            cursor_next = cursor_reg + 5'd1;
                                        end
                                        if ({1'b0, pix_inc} < 9'(SCREEN_WIDTH))
                                        begin
                                            advance = 1'b0;
                                        end
                                    end
                                    if (advance)
                                    begin
                                        if (phase_reg + 4'd1 >= PH_END)
                                        begin
                                            phase_next        = PH_ADDR1;
                                            rendered_next[pg] = 1'b1;
                                            page_next         = page_inc;
                                            pixel_next        = '0;
                                            cursor_next       = '0;
                                        end
                                        else
                                        begin
                                            phase_next = phase_reg + 4'd1;
                                        end
                                    end
                                end
                                else if (item.bus_fault)
                                begin
                                    awaiting_next = 1'b0;
                                    res.status    = ST_FAULT;
                                end
                            end
                            else if (enabled_reg)
                            begin
                                awaiting_next = 1'b1;
                                res.action    = ACT_DATA;
                                case (phase_reg)
                                    PH_ADDR1:
                                    begin
                                        if (rendered_reg[pg])
                                        begin
                                            page_next     = page_inc;
                                            awaiting_next = 1'b0;
                                            res.action    = ACT_NONE;
                                        end
                                        else
                                        begin
                                            res.action = ACT_START;
                                            res.data   = {addr_reg, 1'b0};
                                        end
                                    end
                                    PH_ADDR2:
                                    begin
                                        res.action = ACT_START;
                                        res.data   = {addr_reg, 1'b0};
                                    end
                                    PH_STOP1, PH_STOP2:
                                    begin
                                        stop_next  = 1'b1;
                                        res.action = ACT_STOP;
                                    end
                                    PH_CMD0, PH_COLLO: res.data = CMD_ZERO;
                                    PH_PAGE:  res.data = CMD_PAGE | {5'b0, page_reg};
                                    PH_COLHI: res.data = CMD_COLHI;
                                    PH_DATA1: res.data = CMD_DATA;
                                    PH_DATAN:
                                    begin
                                        if (pixel_reg < start_cur)
                                        begin
                                            res.data = '0;
                                        end
                                        else if ({1'b0, cursor_reg} >= 6'(SLOTS))
                                        begin
                                            ended_next[pg] = 1'b1;
                                        end
                                        else
                                        begin
                                            res_push   = 1'b0;
                                            text_re    = 1'b1;
                                            cidx_next  = cell_pos;
                                            state_next = S_TXT;
                                        end
                                    end
                                    default:
                                    begin
                                        awaiting_next = 1'b0;
                                        res.action    = ACT_NONE;
                                    end
                                endcase
                            end
                        end
                        OP_CHAR, OP_COMMIT, OP_CLEAR:
                        begin
                            if (item.line_bad)
                            begin
                                res.status = ST_BADLINE;
                            end
                            else if (item.opcode == OP_CHAR)
                            begin
                                text_we    = item.slot_ok;
                                text_wdata = item.value;
                            end
                            else if (item.opcode == OP_COMMIT)
                            begin
                                text_we = 1'b1;
                                if (item.align_set)
                                begin
                                    start_next[ln] = item.start;
                                end
                                ended_next[ln]    = 1'b0;
                                rendered_next[ln] = 1'b0;
                            end
                            else
                            begin
                                text_we           = 1'b1;
                                text_waddr        = TAW'(11'(item.line) * 11'(SLOTS));
                                start_next[ln]    = '0;
                                ended_next[ln]    = 1'b0;
                                rendered_next[ln] = 1'b0;
                            end
                        end
                        OP_FONT: font_we = item.gcol_ok;
                        default: ;
                    endcase
                end
            end
            S_TXT:
            begin
                res.action = ACT_DATA;
                if (text_rdata == 8'd0)
                begin
                    ended_next[pg] = 1'b1;
                    res_push       = 1'b1;
                    state_next     = S_EXEC;
                end
                else if (ended_reg[pg] || cidx_reg == 8'(GLYPH_WIDTH))
                begin
                    res_push   = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    font_re    = 1'b1;
                    state_next = S_FNT;
                end
            end
            default:
            begin
                res.action = ACT_DATA;
                res.data   = font_rdata;
                res_push   = 1'b1;
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_waddr] <= text_wdata;
        end
        if (text_re)
        begin
            text_rdata <= text_mem[text_raddr];
        end
        if (font_we)
        begin
            font_mem[font_waddr] <= item.value;
        end
        if (font_re)
        begin
            font_rdata <= font_mem[font_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cidx_reg <= cidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_EXEC;
            enabled_reg  <= 1'b0;
            addr_reg     <= ADDR_RESET;
            phase_reg    <= PH_ADDR1;
            awaiting_reg <= 1'b0;
            stop_reg     <= 1'b0;
            page_reg     <= '0;
            pixel_reg    <= '0;
            cursor_reg   <= '0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                start_reg[i] <= '0;
            end
            ended_reg    <= '0;
            rendered_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            enabled_reg  <= enabled_next;
            addr_reg     <= addr_next;
            phase_reg    <= phase_next;
            awaiting_reg <= awaiting_next;
            stop_reg     <= stop_next;
            page_reg     <= page_next;
            pixel_reg    <= pixel_next;
            cursor_reg   <= cursor_next;
            start_reg    <= start_next;
            ended_reg    <= ended_next;
            rendered_reg <= rendered_next;
        end
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into full queue");
    a_stop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> awaiting_reg)
        else $error("stop pending without bus wait");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < PH_END)
        else $error("phase out of range");
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pixel_reg} <= 9'(SCREEN_WIDTH))
        else $error("pixel column past screen");
`endif

endmodule

/* rtl/oled_text_page_refresher_unit.sv */
// Text page refresher for an SSD1306-style display behind an I2C master. Items enter through
// a queue-like port (push/full) and every item yields exactly one result transaction
// (empty/pop). Most items finish in the execution state; a tick that renders a pixel
// column at or past the line's start column while the character cursor is still inside the
// line also passes the text read state and, for a glyph column, the font read state, as the
// text store and font table have registered read ports. The user must write enabled and
// device_address (cfg_write/cfg_index/cfg_data) only while idle; the block does not check.
module oled_text_page_refresher_unit import otpr_pkg::*; #(
    parameter int LINE_COUNT     = LINE_COUNT_DEF,
    parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
    parameter int GLYPH_WIDTH    = GLYPH_WIDTH_DEF,
    parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [2:0] opcode,
    input  logic       bus_done,
    input  logic       bus_nack,
    input  logic       bus_fault,
    input  logic [2:0] line_index,
    input  logic [4:0] char_position,
    input  logic [7:0] byte_value,
    input  logic [7:0] glyph_index,
    input  logic [2:0] glyph_column,
    input  logic [1:0] alignment,
    input  logic [4:0] text_length,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] bus_action,
    output logic [7:0] bus_byte,
    output logic [1:0] status
);

    localparam int RW = $bits(result_t);

    item_t         item;
    logic          item_valid, item_pop;
    logic          out_full, res_push, out_valid;
    result_t       res, out_res;
    logic [RW-1:0] out_rdata;
    cfg_t          cfg;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    otpr_front #(
        .LINE_COUNT    (LINE_COUNT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .GLYPH_WIDTH   (GLYPH_WIDTH),
        .CHARS_PER_LINE(CHARS_PER_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .bus_done     (bus_done),
        .bus_nack     (bus_nack),
        .bus_fault    (bus_fault),
        .line_index   (line_index),
        .char_position(char_position),
        .byte_value   (byte_value),
        .glyph_index  (glyph_index),
        .glyph_column (glyph_column),
        .alignment    (alignment),
        .text_length  (text_length),
        .item_pop     (item_pop),
        .item_valid   (item_valid),
        .item         (item)
    );

    otpr_back #(
        .LINE_COUNT    (LINE_COUNT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .GLYPH_WIDTH   (GLYPH_WIDTH),
        .CHARS_PER_LINE(CHARS_PER_LINE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_valid(item_valid),
        .item      (item),
        .item_pop  (item_pop),
        .out_full  (out_full),
        .res_push  (res_push),
        .res       (res)
    );

    otpr_queue #(
        .WIDTH(RW),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res),
        .full (out_full),
        .pop  (pop),
        .rdata(out_rdata),
        .valid(out_valid)
    );

    assign out_res    = out_rdata;
    assign empty      = !out_valid;
    assign bus_action = out_res.action;
    assign bus_byte   = out_res.data;
    assign status     = out_res.status;

endmodule

/* sim/tb.sv */
module tb;
    import otpr_pkg::*;

    localparam int LINES  = 8;
    localparam int WIDTH  = 128;
    localparam int GLYPH  = 5;
    localparam int CPL    = 21;
    localparam int SLOTS  = CPL + 1;
    localparam int CELLW  = GLYPH + 1;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [2:0] op;
        logic       done;
        logic       nack;
        logic       fault;
        logic [2:0] line;
        logic [4:0] pos;
        logic [7:0] val;
        logic [7:0] glyph;
        logic [2:0] gcol;
        logic [1:0] align;
        logic [4:0] len;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic [1:0] status;
    } bus_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [6:0] cfg_data = '0;
    logic       push = 1'b0;
    logic       full;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] bus_action;
    logic [7:0] bus_byte;
    logic [1:0] status;
    cmd_t       cur = '0;

    oled_text_page_refresher_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .opcode(cur.op), .bus_done(cur.done), .bus_nack(cur.nack), .bus_fault(cur.fault),
        .line_index(cur.line), .char_position(cur.pos), .byte_value(cur.val),
        .glyph_index(cur.glyph), .glyph_column(cur.gcol), .alignment(cur.align),
        .text_length(cur.len),
        .empty(empty), .pop(pop),
        .bus_action(bus_action), .bus_byte(bus_byte), .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // display model state
    logic [7:0] txt [LINES][SLOTS];
    logic [7:0] font [256*GLYPH];
    logic [7:0] start_col [LINES];
    logic       ended [LINES];
    logic       rendered [LINES];
    logic [3:0] phase;
    logic       waiting;
    logic       stop_pend;
    logic [2:0] page;
    logic [7:0] pix;
    logic [4:0] cursor;
    logic       en_m = 1'b0;
    logic [6:0] addr_m = ADDR_RESET;

    cmd_t     pend_cmds [$];
    bus_res_t bus_expect [$];
    int       mismatches = 0;
    int       n_items = 0;
    int       n_results = 0;
    int       n_data = 0;
    int       n_fault = 0;
    int       cycles = 0;

    initial
    begin
        for (int l = 0; l < LINES; l++)
        begin
            start_col[l] = '0;
            ended[l] = 1'b0;
            rendered[l] = 1'b0;
        end
        phase = PH_ADDR1;
        waiting = 1'b0;
        stop_pend = 1'b0;
        page = '0;
        pix = '0;
        cursor = '0;
    end

    function automatic logic [7:0] pixel_byte();
        logic [7:0] c;
        int         i;
        if (pix < start_col[page])
            return 8'h00;
        c = (cursor < SLOTS) ? txt[page][cursor] : 8'h00;
        if (c == 8'h00)
            ended[page] = 1'b1;
        i = (int'(pix) - int'(start_col[page])) % CELLW;
        if (ended[page] || i == GLYPH)
            return 8'h00;
        return font[int'(c) * GLYPH + i];
    endfunction

    function automatic bus_res_t sequence_tick(cmd_t t);
        bus_res_t r;
        logic [7:0] old;
        r = '{ACT_NONE, 8'h00, ST_OK};
        if (!en_m)
            return r;
        if (waiting)
        begin
            if (stop_pend || (t.done && !t.nack))
            begin
                stop_pend = 1'b0;
                if (phase == PH_DATAN)
                begin
                    old = pix;
                    pix = pix + 8'd1;
                    if (old >= start_col[page] &&
                        ((int'(pix) - int'(start_col[page])) % CELLW) == 0 &&
                        cursor < CURSOR_MAX)
                        cursor = cursor + 5'd1;
                    if (pix < WIDTH)
                    begin
                        waiting = 1'b0;
                        return r;
                    end
                end
                phase = phase + 4'd1;
                if (phase >= PH_END)
                begin
                    phase = PH_ADDR1;
                    rendered[page] = 1'b1;
                    page = page + 3'd1;
                    pix = '0;
                    cursor = '0;
                end
                waiting = 1'b0;
            end
            else if (t.fault)
            begin
                waiting = 1'b0;
                r.status = ST_FAULT;
            end
            return r;
        end
        case (phase)
            PH_ADDR1:
            begin
                if (rendered[page])
                begin
                    page = page + 3'd1;
                    return r;
                end
                r = '{ACT_START, {addr_m, 1'b0}, ST_OK};
            end
            PH_ADDR2: r = '{ACT_START, {addr_m, 1'b0}, ST_OK};
            PH_STOP1, PH_STOP2:
            begin
                stop_pend = 1'b1;
                r.action = ACT_STOP;
            end
            PH_CMD0, PH_COLLO: r = '{ACT_DATA, CMD_ZERO, ST_OK};
            PH_PAGE: r = '{ACT_DATA, CMD_PAGE | {5'b0, page}, ST_OK};
            PH_COLHI: r = '{ACT_DATA, CMD_COLHI, ST_OK};
            PH_DATA1: r = '{ACT_DATA, CMD_DATA, ST_OK};
            PH_DATAN: r = '{ACT_DATA, pixel_byte(), ST_OK};
            default: return r;
        endcase
        waiting = 1'b1;
        return r;
    endfunction

    function automatic bus_res_t display_step(cmd_t t);
        bus_res_t r;
        int n;
        int w;
        r = '{ACT_NONE, 8'h00, ST_OK};
        case (t.op)
            OP_TICK: r = sequence_tick(t);
            OP_CHAR:
                if (t.pos < SLOTS)
                    txt[t.line][t.pos] = t.val;
            OP_COMMIT:
            begin
                n = (t.len > CPL) ? CPL : int'(t.len);
                txt[t.line][n] = 8'h00;
                w = n * CELLW;
                if (t.align == ALIGN_LEFT)
                    start_col[t.line] = 8'd0;
                else if (t.align == ALIGN_RIGHT)
                    start_col[t.line] = (w < WIDTH) ? 8'(WIDTH - w) : 8'd0;
                else if (t.align == ALIGN_CENTER)
                    start_col[t.line] = (w < WIDTH) ? 8'((WIDTH - w) >> 1) : 8'd0;
                ended[t.line] = 1'b0;
                rendered[t.line] = 1'b0;
            end
            OP_CLEAR:
            begin
                txt[t.line][0] = 8'h00;
                start_col[t.line] = 8'd0;
                ended[t.line] = 1'b0;
                rendered[t.line] = 1'b0;
            end
            OP_FONT:
                if (t.gcol < GLYPH)
                    font[int'(t.glyph) * GLYPH + int'(t.gcol)] = t.val;
            default: ;
        endcase
        return r;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                bus_expect.push_back(display_step(cur));
                void'(pend_cmds.pop_front());
                n_items++;
            end
            if (push && full)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pend_cmds.size() > 0)
            begin
                push <= 1'b1;
                cur <= pend_cmds[0];
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                push <= 1'b0;
        end
    end

    // monitor with its own stall pattern and one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    always @(posedge clk)
    begin
        bus_res_t e;
        if (rst_n)
        begin
            cycles++;
            if (pop && !empty)
            begin
                n_results++;
                if (bus_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %0d %02h %0d",
                                 bus_action, bus_byte, status);
                end
                else
                begin
                    e = bus_expect.pop_front();
                    if (e.action == ACT_DATA && bus_action == ACT_DATA)
                        n_data++;
                    if (e.status == ST_FAULT)
                        n_fault++;
                    if (bus_action !== e.action || bus_byte !== e.data
                        || status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at txn %0d: exp %0d/%02h/%0d got %0d/%02h/%0d",
                                     n_results, e.action, e.data, e.status,
                                     bus_action, bus_byte, status);
                    end
                end
            end
            if (!hold_done && n_items > 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (cycles % 97 == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_mode == 0)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("oled_text_page_refresher_unit verification failed");
            $finish;
        end
    end

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int k;
        c = cmd_t'(40'({$urandom, $urandom}));
        k = $urandom_range(0, 99);
        if (k < 70)
        begin
            c.op = OP_TICK;
            if ($urandom_range(0, 9) != 0)
            begin
                c.done = 1'b1;
                c.nack = 1'b0;
            end
        end
        else if (k < 82)
        begin
            c.op = OP_CHAR;
            // character codes stay within the glyphs loaded at start
            c.val = {c.val[7], 3'b000, c.val[3:0]};
        end
        else if (k < 87)
        begin
            c.op = OP_COMMIT;
            c.len = $urandom_range(0, 31);
        end
        else if (k < 89)
            c.op = OP_CLEAR;
        else if (k < 97)
            c.op = OP_FONT;
        else
            c.op = 3'($urandom_range(5, 7));
        return c;
    endfunction

    function automatic cmd_t mk(logic [2:0] op, logic [2:0] line, logic [4:0] pos,
                                logic [7:0] val, logic [1:0] align, logic [4:0] len);
        cmd_t c;
        c = '0;
        c.op = op; c.line = line; c.pos = pos; c.val = val;
        c.glyph = val; c.gcol = pos[2:0]; c.align = align; c.len = len;
        return c;
    endfunction

    function automatic cmd_t mk_tick(logic d, logic n, logic f);
        cmd_t c;
        c = '0;
        c.op = OP_TICK; c.done = d; c.nack = n; c.fault = f;
        return c;
    endfunction

    task automatic drain();
        wait (pend_cmds.size() == 0 && !push && bus_expect.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        if (idx == CFG_ENABLED)
            en_m = v[0];
        else
            addr_m = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            pend_cmds.push_back(rand_cmd());
    endtask

    initial
    begin
        cmd_t f;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // fill every text slot and the glyphs in use before anything is rendered
        for (int l = 0; l < LINES; l++)
            for (int p = 0; p < SLOTS; p++)
                pend_cmds.push_back(mk(OP_CHAR, 3'(l), 5'(p), 8'h00, ALIGN_LEFT, 5'd0));
        for (int g = 0; g < 32; g++)
            for (int k = 0; k < GLYPH; k++)
            begin
                f = mk(OP_FONT, 3'd0, 5'd0, 8'($urandom), ALIGN_LEFT, 5'd0);
                f.glyph = 8'((g / 16) * 128 + g % 16);
                f.gcol = 3'(k);
                pend_cmds.push_back(f);
            end
        pend_cmds.push_back(mk_tick(1'b1, 1'b0, 1'b0));
        drain();
        write_reg(CFG_ENABLED, 7'd1);
        write_reg(CFG_ADDRESS, 7'd0);

        // directed corners
        pend_cmds.push_back(mk(3'd5, 3'd7, 5'd31, 8'hFF, 2'd3, 5'd31));
        pend_cmds.push_back(mk(3'd6, 3'd0, 5'd0, 8'h00, 2'd0, 5'd0));
        pend_cmds.push_back(mk(3'd7, 3'd1, 5'd1, 8'h01, 2'd1, 5'd1));
        pend_cmds.push_back(mk(OP_FONT, 3'd0, 5'd5, 8'hAA, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_FONT, 3'd0, 5'd7, 8'h55, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_CHAR, 3'd0, 5'd22, 8'h41, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_CHAR, 3'd0, 5'd31, 8'h41, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_CHAR, 3'd0, 5'd0, 8'h8F, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_CHAR, 3'd0, 5'd21, 8'h80, 2'd0, 5'd0));
        pend_cmds.push_back(mk(OP_COMMIT, 3'd0, 5'd0, 8'h00, ALIGN_RIGHT, 5'd21));
        pend_cmds.push_back(mk(OP_COMMIT, 3'd1, 5'd0, 8'h00, ALIGN_CENTER, 5'd31));
        pend_cmds.push_back(mk(OP_COMMIT, 3'd2, 5'd0, 8'h00, 2'd3, 5'd4));
        pend_cmds.push_back(mk(OP_COMMIT, 3'd3, 5'd0, 8'h00, ALIGN_RIGHT, 5'd0));
        pend_cmds.push_back(mk(OP_COMMIT, 3'd4, 5'd0, 8'h00, ALIGN_CENTER, 5'd3));
        pend_cmds.push_back(mk(OP_CLEAR, 3'd7, 5'd0, 8'h00, 2'd0, 5'd0));
        pend_cmds.push_back(mk_tick(1'b0, 1'b0, 1'b0));
        pend_cmds.push_back(mk_tick(1'b0, 1'b0, 1'b0));
        pend_cmds.push_back(mk_tick(1'b1, 1'b1, 1'b0));
        pend_cmds.push_back(mk_tick(1'b0, 1'b1, 1'b0));
        pend_cmds.push_back(mk_tick(1'b0, 1'b0, 1'b1));
        pend_cmds.push_back(mk_tick(1'b0, 1'b0, 1'b0));
        pend_cmds.push_back(mk_tick(1'b1, 1'b0, 1'b1));
        pend_cmds.push_back(mk_tick(1'b1, 1'b0, 1'b0));
        drain();

        random_run(100);
        drain();
        write_reg(CFG_ADDRESS, 7'd127);
        random_run(80);
        drain();
        write_reg(CFG_ENABLED, 7'd0);
        random_run(20);
        drain();
        write_reg(CFG_ADDRESS, 7'($urandom));
        write_reg(CFG_ENABLED, 7'd1);
        random_run(60);
        drain();

        $display("%0d items, %0d transactions, %0d pixel/command bytes, %0d fault reports",
                 n_items, n_results, n_data, n_fault);
        $display("address settings 0, 127, random; enable toggled; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("oled_text_page_refresher_unit verification clean");
        else
            $display("oled_text_page_refresher_unit verification failed");
        $finish;
    end
endmodule
